// File: design/gb3_pkg.sv
// shared types and constants for the 3x3 gaussian blur
package gb3_pkg;

  localparam int CFG_BITS    = 11;
  localparam int PIX_IN_BITS = 16;
  localparam int BLUR_BITS   = 20;
  localparam int POS_BITS    = 10;
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = 11'd1024;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // per-pixel tag handed from the front to the back
  typedef struct packed {
    logic                emit;
    logic                last;
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
  } gb3_ctrl_t;

endpackage

// File: design/gb3_stream_if.sv
// valid/ready stream interfaces for pixels in and filtered results out
interface gb3_pix_if import gb3_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [PIX_IN_BITS-1:0] pixel;
  logic                   frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface gb3_res_if import gb3_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [BLUR_BITS-1:0] blurred;
  logic [POS_BITS-1:0]  out_row;
  logic [POS_BITS-1:0]  out_col;
  logic                 last;

  modport source (output valid, blurred, out_row, out_col, last, input ready);
  modport sink   (input valid, blurred, out_row, out_col, last, output ready);
endinterface

// File: design/gb3_ram.sv
// generic single-write, single-read ram with registered read data
module gb3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/gb3_front.sv
// front end: position counters, line buffer access and column assembly
module gb3_front import gb3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PW         = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [CFG_BITS-1:0]    frame_width_i,
  input  logic [CFG_BITS-1:0]    frame_height_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [PIX_IN_BITS-1:0] in_pixel_i,
  input  logic                   in_frame_start_i,
  input  logic [QCNT_BITS-1:0]   q_count_i,
  output logic                   push_o,
  output gb3_ctrl_t              push_ctrl_o,
  output logic [3*PW-1:0]        push_pix_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WCW = (CW + 1 > CFG_BITS) ? CW + 1 : CFG_BITS;
  localparam int HCW = (RW + 1 > CFG_BITS) ? RW + 1 : CFG_BITS;

  logic [CW-1:0] col_q, col_d, c0;
  logic [RW-1:0] row_q, row_d, r0;
  logic [WCW-1:0] w_ext, w_eff;
  logic [HCW-1:0] h_ext, h_eff;
  logic           accept, col_end, row_end;
  gb3_ctrl_t      ctrl_d;
  logic [31:0]    row_m1, col_m1;

  logic            s1_valid_q;
  logic [CW-1:0]   s1_col_q;
  logic [PW-1:0]   s1_pix_q;
  gb3_ctrl_t       s1_ctrl_q;
  logic            byp_q;
  logic [2*PW-1:0] byp_data_q;

  logic [2*PW-1:0] ram_rdata, rd_data, ram_wdata;
  logic [PW-1:0]   top, mid;

  // clamp frame size to the supported range
  always_comb begin
    w_ext = WCW'(frame_width_i);
    h_ext = HCW'(frame_height_i);
    if (w_ext < WCW'(3)) begin
      w_eff = WCW'(3);
    end else if (w_ext > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext < HCW'(3)) begin
      h_eff = HCW'(3);
    end else if (h_ext > HCW'(MAX_HEIGHT)) begin
      h_eff = HCW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
  end

  assign in_ready_o = (QCNT_BITS'(q_count_i) + QCNT_BITS'(s1_valid_q)) <
                      QCNT_BITS'(QUEUE_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    r0      = in_frame_start_i ? '0 : row_q;
    c0      = in_frame_start_i ? '0 : col_q;
    col_end = (WCW'(c0) + WCW'(1)) >= w_eff;
    row_end = (HCW'(r0) + HCW'(1)) >= h_eff;
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : r0 + RW'(1);
      end else begin
        col_d = c0 + CW'(1);
        row_d = r0;
      end
    end
    row_m1      = 32'(r0) - 32'd1;
    col_m1      = 32'(c0) - 32'd1;
    ctrl_d.emit = (r0 >= RW'(2)) && (c0 >= CW'(2));
    ctrl_d.last = (HCW'(r0) == h_eff - HCW'(1)) && (WCW'(c0) == w_eff - WCW'(1));
    ctrl_d.row  = row_m1[POS_BITS-1:0];
    ctrl_d.col  = col_m1[POS_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      s1_valid_q <= accept;
    end
  end

  // the entry written in the same cycle as the read is not yet in the ram
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q   <= c0;
      s1_pix_q   <= in_pixel_i[PW-1:0];
      s1_ctrl_q  <= ctrl_d;
      byp_q      <= s1_valid_q && (s1_col_q == c0);
      byp_data_q <= ram_wdata;
    end
  end

  // each entry holds {line above, line two above}
  gb3_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (c0),
    .rdata_o (ram_rdata)
  );

  assign rd_data   = byp_q ? byp_data_q : ram_rdata;
  assign top       = rd_data[PW-1:0];
  assign mid       = rd_data[2*PW-1:PW];
  assign ram_wdata = {s1_pix_q, mid};

  assign push_o      = s1_valid_q;
  assign push_ctrl_o = s1_ctrl_q;
  assign push_pix_o  = {top, mid, s1_pix_q};

endmodule

// File: design/gb3_fifo.sv
// short register queue between front and back
module gb3_fifo import gb3_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     rdata_o,
  output logic                 empty_o,
  output logic [QCNT_BITS-1:0] count_o
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0]     slot_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_BITS'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = slot_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

// File: design/gb3_back.sv
// back end: window registers, kernel sum and output register
module gb3_back import gb3_pkg::*; #(
  parameter int PW = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  gb3_ctrl_t             q_ctrl_i,
  input  logic [3*PW-1:0]       q_pix_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [BLUR_BITS-1:0]  out_blurred_o,
  output logic [POS_BITS-1:0]   out_row_o,
  output logic [POS_BITS-1:0]   out_col_o,
  output logic                  out_last_o
);

  localparam int SW = PW + 4;

  // [0..2] column c-2 top/mid/bot, [3..5] column c-1
  logic [PW-1:0] win_q [6];
  logic [PW-1:0] top, mid, bot;
  logic [SW-1:0] sum;
  logic [31:0]   sum_ext;

  logic                 ovalid_q, ovalid_d;
  logic [BLUR_BITS-1:0] blurred_q;
  logic [POS_BITS-1:0]  row_q, col_q;
  logic                 last_q;

  assign top = q_pix_i[3*PW-1:2*PW];
  assign mid = q_pix_i[2*PW-1:PW];
  assign bot = q_pix_i[PW-1:0];

  assign pop_o = !q_empty_i && (!ovalid_q || out_ready_i);

  always_comb begin
    sum = SW'(win_q[0]) + (SW'(win_q[3]) << 1) + SW'(top)
        + (SW'(win_q[1]) << 1) + (SW'(win_q[4]) << 2) + (SW'(mid) << 1)
        + SW'(win_q[2]) + (SW'(win_q[5]) << 1) + SW'(bot);
    sum_ext = 32'(sum);
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (pop_o) begin
      ovalid_d = q_ctrl_i.emit;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      ovalid_q <= ovalid_d;
      if (pop_o) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top;
        win_q[4] <= mid;
        win_q[5] <= bot;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && q_ctrl_i.emit) begin
      blurred_q <= sum_ext[BLUR_BITS-1:0];
      row_q     <= q_ctrl_i.row;
      col_q     <= q_ctrl_i.col;
      last_q    <= q_ctrl_i.last;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign out_blurred_o = blurred_q;
  assign out_row_o     = row_q;
  assign out_col_o     = col_q;
  assign out_last_o    = last_q;

endmodule

// File: design/gaussian_blur_3x3.sv
// top level of the 3x3 gaussian blur over a raster pixel stream
//
//   channel   direction  transfer when        carries
//   pix_in    in         valid && ready       pixel, frame_start
//   res_out   out        valid && ready       blurred, out_row, out_col, last
//   cfg       in         cfg_we_i             frame_width (0), frame_height (1)
//
// one pixel per clock sustained while results are taken; a pixel reaches the queue
// in the cycle after its transfer (line ram read and column assembly)
// the single line ram port pair (one read, one write per cycle) sets the one pixel rate
// reset clears counters, window and queue; line buffer contents are not cleared
// a stalled output fills the four-entry queue, after which pix_in.ready drops
module gaussian_blur_3x3 import gb3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  gb3_pix_if.sink             pix_in,
  gb3_res_if.source           res_out,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [CFG_BITS-1:0] cfg_data_i
);

  localparam int PW = (PIXEL_BITS < PIX_IN_BITS) ? PIXEL_BITS : PIX_IN_BITS;
  localparam int QW = $bits(gb3_ctrl_t) + 3 * PW;

  logic [CFG_BITS-1:0]  frame_width_q, frame_height_q;
  logic                 push, pop, q_empty;
  gb3_ctrl_t            push_ctrl, pop_ctrl;
  logic [3*PW-1:0]      push_pix, pop_pix;
  logic [QCNT_BITS-1:0] q_count;
  logic [QW-1:0]        q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gb3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PW         (PW)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .frame_width_i    (frame_width_q),
    .frame_height_i   (frame_height_q),
    .in_valid_i       (pix_in.valid),
    .in_ready_o       (pix_in.ready),
    .in_pixel_i       (pix_in.pixel),
    .in_frame_start_i (pix_in.frame_start),
    .q_count_i        (q_count),
    .push_o           (push),
    .push_ctrl_o      (push_ctrl),
    .push_pix_o       (push_pix)
  );

  gb3_fifo #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({push_ctrl, push_pix}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  assign pop_ctrl = q_rdata[QW-1:3*PW];
  assign pop_pix  = q_rdata[3*PW-1:0];

  gb3_back #(
    .PW (PW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_ctrl_i      (pop_ctrl),
    .q_pix_i       (pop_pix),
    .pop_o         (pop),
    .out_valid_o   (res_out.valid),
    .out_ready_i   (res_out.ready),
    .out_blurred_o (res_out.blurred),
    .out_row_o     (res_out.out_row),
    .out_col_o     (res_out.out_col),
    .out_last_o    (res_out.last)
  );

endmodule

// File: design/gb3_checker.sv
// port-level checks on the blur top level, attached by bind
module gb3_checker import gb3_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [BLUR_BITS-1:0] out_blurred,
  input logic [POS_BITS-1:0]  out_row,
  input logic [POS_BITS-1:0]  out_col,
  input logic                 out_last
);

  // pixels transferred in minus results transferred out
  logic [31:0] credit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_q + 32'(in_valid && in_ready) - 32'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_blurred) && $stable(out_row) &&
                                $stable(out_col) && $stable(out_last))
    else $error("result payload changed while stalled");

  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_row != '0 && out_col != '0)
    else $error("border position reported");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> credit_q != '0)
    else $error("result shown without a pixel to account for it");

endmodule

bind gaussian_blur_3x3 gb3_checker u_gb3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (pix_in.valid),
  .in_ready    (pix_in.ready),
  .out_valid   (res_out.valid),
  .out_ready   (res_out.ready),
  .out_blurred (res_out.blurred),
  .out_row     (res_out.out_row),
  .out_col     (res_out.out_col),
  .out_last    (res_out.last)
);

// File: sim/tb_gaussian_blur_3x3.sv
`timescale 1ns / 1ps
// testbench for gaussian_blur_3x3: predicts every blurred pixel and checks the output stream
module tb_gaussian_blur_3x3 import gb3_pkg::*;;

  localparam int LINE_DEPTH   = 1024;
  localparam int HANG_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int SMALL_AREA   = 400;

  typedef struct packed {
    logic [BLUR_BITS-1:0] blurred;
    logic [POS_BITS-1:0]  row;
    logic [POS_BITS-1:0]  col;
    logic                 last;
  } blur_px_t;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;
  typedef enum int {
    SEQ_FRAME, SEQ_CONTINUE, SEQ_TRUNCATED, SEQ_RESIZE, SEQ_NOISE, SEQ_CLAMPED
  } seq_kind_e;

  class blur_scoreboard;
    bit [15:0]         upper_line  [LINE_DEPTH];
    bit [15:0]         upper2_line [LINE_DEPTH];
    bit [15:0]         win [6];
    int unsigned       row_pos;
    int unsigned       col_pos;
    bit [CFG_BITS-1:0] width_reg  = FRAME_WIDTH_RST;
    bit [CFG_BITS-1:0] height_reg = FRAME_HEIGHT_RST;
    blur_px_t          pending_blurs [$];
    int unsigned       blurs_checked;

    function int unsigned clamp_size(bit [CFG_BITS-1:0] v, int unsigned top_size);
      if (v < 3) return 3;
      if (v > top_size) return top_size;
      return v;
    endfunction

    function int unsigned eff_width();
      return clamp_size(width_reg, LINE_DEPTH);
    endfunction

    function int unsigned eff_height();
      return clamp_size(height_reg, 1024);
    endfunction

    function bit at_origin();
      return row_pos == 0 && col_pos == 0;
    endfunction

    function int pending();
      return pending_blurs.size();
    endfunction

    function void note_config(cfg_reg_e idx, bit [CFG_BITS-1:0] value);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg  = value;
        CFG_FRAME_HEIGHT: height_reg = value;
        default: ;
      endcase
    endfunction

    function void take_pixel(bit [15:0] value, bit fs);
      int unsigned w, h, idx;
      bit [15:0]   top, mid;
      bit [19:0]   sum;
      blur_px_t    res;
      w = eff_width();
      h = eff_height();
      if (fs) begin
        row_pos = 0;
        col_pos = 0;
      end
      idx = (col_pos < LINE_DEPTH) ? col_pos : 0;
      top = upper2_line[idx];
      mid = upper_line[idx];
      upper2_line[idx] = mid;
      upper_line[idx]  = value;
      // the incoming pixel completes the window centered one row up, one column left
      if (row_pos >= 2 && col_pos >= 2) begin
        sum = 20'(win[0] + 2 * win[3] + top
            + 2 * (win[1] + 2 * win[4] + mid)
            + win[2] + 2 * win[5] + value);
        res.blurred = sum;
        res.row     = POS_BITS'(row_pos - 1);
        res.col     = POS_BITS'(col_pos - 1);
        res.last    = (row_pos == h - 1) && (col_pos == w - 1);
        pending_blurs.push_back(res);
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = value;
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
    endfunction

    function string check_blur(blur_px_t got);
      blur_px_t want;
      if (pending_blurs.size() == 0)
        return $sformatf("unexpected result: blurred %0d row %0d col %0d last %0b",
                         got.blurred, got.row, got.col, got.last);
      want = pending_blurs.pop_front();
      blurs_checked++;
      if (got !== want)
        return $sformatf("got blurred %0d row %0d col %0d last %0b, want %0d %0d %0d %0b",
                         got.blurred, got.row, got.col, got.last,
                         want.blurred, want.row, want.col, want.last);
      return "";
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [0:0]          cfg_idx_i;
  logic [CFG_BITS-1:0] cfg_data_i;
  logic                rx_hold;
  int                  tx_idle_pct;
  int                  rx_idle_pct;
  int                  idle_cycles;
  int                  error_count;
  int                  pixels_sent;
  int                  config_writes;
  int                  mid_frame_changes;
  blur_px_t            seen_blur;
  string               blur_msg;
  blur_scoreboard      sb;

  gb3_pix_if pix_in ();
  gb3_res_if res_out ();

  gaussian_blur_3x3 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_in     (pix_in),
    .res_out    (res_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  task automatic report(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || rx_hold) begin
      res_out.ready <= 1'b0;
    end else begin
      res_out.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_out.valid && res_out.ready) begin
        seen_blur = '{res_out.blurred, res_out.out_row, res_out.out_col, res_out.last};
        blur_msg  = sb.check_blur(seen_blur);
        if (blur_msg != "") report(blur_msg);
      end
      if (pix_in.valid && pix_in.ready) sb.take_pixel(pix_in.pixel, pix_in.frame_start);
      if (cfg_we_i) sb.note_config(cfg_reg_e'(cfg_idx_i), cfg_data_i);
    end
  end

  // hang detection: no transfer on either stream for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_in.valid && pix_in.ready) || (res_out.valid && res_out.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               HANG_LIMIT, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct <= tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  function automatic logic [15:0] pick_pixel(fill_e mode);
    case (mode)
      FILL_ONES:  return 16'hFFFF;
      FILL_ZEROS: return 16'h0000;
      default: begin
        case ($urandom_range(9))
          0:       return 16'hFFFF;
          1:       return 16'h0000;
          default: return 16'($urandom());
        endcase
      end
    endcase
  endfunction

  task automatic send_pixel(input logic [15:0] value, input logic fs);
    while ($urandom_range(99) < tx_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid       <= 1'b1;
    pix_in.pixel       <= value;
    pix_in.frame_start <= fs;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    pixels_sent++;
  endtask

  task automatic send_frame(input int unsigned count, input logic first_fs, input fill_e mode);
    for (int unsigned i = 0; i < count; i++) send_pixel(pick_pixel(mode), first_fs && i == 0);
  endtask

  // stop sending and let the block empty out
  task automatic drain();
    pix_in.valid <= 1'b0;
    // the last transfer is noted by the monitor at this edge, so wait for it first
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FRAME_WIDTH;
    cfg_data_i <= CFG_BITS'(w);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FRAME_HEIGHT;
    cfg_data_i <= CFG_BITS'(h);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    config_writes += 2;
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned start_count, w, h, area;
    int          pick;
    seq_kind_e   kind;
    start_count = pixels_sent;
    while (pixels_sent - start_count < quota) begin
      pick = $urandom_range(9);
      kind = (pick < 5) ? SEQ_FRAME : seq_kind_e'(pick - 4);
      area = sb.eff_width() * sb.eff_height();
      case (kind)
        SEQ_FRAME: begin
          w = ($urandom_range(3) == 0) ? $urandom_range(3, 40) : $urandom_range(3, 10);
          h = $urandom_range(3, 8);
          if (w != sb.eff_width() || h != sb.eff_height()) configure(w, h);
          send_frame(w * h, 1'b1, FILL_RANDOM);
        end
        SEQ_CONTINUE: begin
          // counters wrapped at frame end, next frame follows without a start flag
          if (sb.at_origin() && area <= SMALL_AREA) send_frame(area, 1'b0, FILL_RANDOM);
        end
        SEQ_TRUNCATED: begin
          if (area <= SMALL_AREA) send_frame($urandom_range(1, area - 1), 1'b1, FILL_RANDOM);
        end
        SEQ_RESIZE: begin
          // width only shrinks mid-frame so line buffer reads stay on written entries
          if (area <= SMALL_AREA) begin
            send_frame($urandom_range(1, area - 1), 1'b1, FILL_RANDOM);
            configure($urandom_range(0, sb.eff_width()), $urandom_range(0, 12));
            mid_frame_changes++;
            send_frame($urandom_range(5, 40), 1'b0, FILL_RANDOM);
          end
        end
        SEQ_NOISE: begin
          for (int i = $urandom_range(3, 30); i > 0; i--)
            send_pixel(pick_pixel(FILL_RANDOM), $urandom_range(9) == 0);
        end
        default: begin
          // register values below the minimum are clamped to 3
          configure($urandom_range(0, 2), $urandom_range(0, 2));
          send_frame(9, 1'b1, FILL_RANDOM);
        end
      endcase
    end
  endtask

  initial begin
    sb                 = new;
    rst_ni             = 1'b0;
    rx_hold            = 1'b0;
    tx_idle_pct        = 0;
    rx_idle_pct        = 0;
    error_count        = 0;
    pixels_sent        = 0;
    config_writes      = 0;
    mid_frame_changes  = 0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_FRAME_WIDTH;
    cfg_data_i         = '0;
    pix_in.valid       = 1'b0;
    pix_in.pixel       = '0;
    pix_in.frame_start = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0, 0);
    // smallest frame: saturated pixels give the largest sum, then a zero frame with no start flag
    configure(3, 3);
    send_frame(9, 1'b1, FILL_ONES);
    send_frame(9, 1'b0, FILL_ZEROS);

    // long output hold-off while pixels keep coming, so the queue fills and input stalls
    configure(12, 12);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    send_frame(144, 1'b1, FILL_RANDOM);
    drain();

    // register values above the maximum clamp to 1024 columns or rows
    configure(2047, 3);
    send_frame(60, 1'b1, FILL_RANDOM);
    configure(3, 1500);
    send_frame(60, 1'b1, FILL_RANDOM);

    run_random(140);
    set_idling(88, 0);
    run_random(140);
    set_idling(0, 88);
    run_random(140);
    set_idling(19, 19);
    run_random(140);

    drain();
    $display("covered %0d pixels, %0d blurred results, %0d register writes",
             pixels_sent, sb.blurs_checked, config_writes);
    $display("%0d mid-frame resizes, sizes from 3x3 to clamped maximum, under idle and stall mixes",
             mid_frame_changes);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
